/* src/cdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types, codes and reset values for the countdown timer core.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int TIME_WIDTH_DEF = 16;
  localparam int APB_AW         = 5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TIME_STEP   = 3'd0;
  localparam logic [2:0] REG_MAX_TIME    = 3'd1;
  localparam logic [2:0] REG_COUNT_DIV   = 3'd2;
  localparam logic [2:0] REG_STAT_HOLD   = 3'd3;
  localparam logic [2:0] REG_BEEP_PHASE  = 3'd4;

  localparam logic [7:0]  RST_TIME_STEP  = 8'd60;
  localparam logic [15:0] RST_MAX_TIME   = 16'd3600;
  localparam logic [7:0]  RST_COUNT_DIV  = 8'd10;
  localparam logic [7:0]  RST_STAT_HOLD  = 8'd30;
  localparam logic [3:0]  RST_BEEP_PHASE = 4'd5;

  // Event codes
  localparam logic [2:0] MODE_INC   = 3'd0;
  localparam logic [2:0] MODE_DEC   = 3'd1;
  localparam logic [2:0] MODE_TICK  = 3'd2;
  localparam logic [2:0] MODE_SS    = 3'd3;
  localparam logic [2:0] MODE_ABORT = 3'd4;

  localparam logic [1:0] STATUS_IGNORED    = 2'd0;
  localparam logic [1:0] STATUS_HANDLED    = 2'd1;
  localparam logic [1:0] STATUS_TRANSITION = 2'd2;

  localparam logic [1:0] MSG_NONE       = 2'd0;
  localparam logic [1:0] MSG_SET_TIME   = 2'd1;
  localparam logic [1:0] MSG_PAUSED     = 2'd2;
  localparam logic [1:0] MSG_PRODUCTIVE = 2'd3;

  // State codes as reported on the result channel
  localparam logic [2:0] NS_IDLE      = 3'd0;
  localparam logic [2:0] NS_TIME_SET  = 3'd1;
  localparam logic [2:0] NS_COUNTDOWN = 3'd2;
  localparam logic [2:0] NS_PAUSE     = 3'd3;
  localparam logic [2:0] NS_STAT      = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SET   = 5'b00010,
    ST_CD    = 5'b00100,
    ST_PAUSE = 5'b01000,
    ST_STAT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [7:0]  time_step;
    logic [15:0] max_time;
    logic [7:0]  count_divider;
    logic [7:0]  stat_hold_ticks;
    logic [3:0]  beep_phase;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] sub_second;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  new_state;
    logic        clear_display;
    logic [1:0]  message;
    logic        show_time;
    logic [15:0] time_value;
    logic        beep;
  } res_t;

  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] code;
    unique case (s)
      ST_IDLE:  code = NS_IDLE;
      ST_SET:   code = NS_TIME_SET;
      ST_CD:    code = NS_COUNTDOWN;
      ST_PAUSE: code = NS_PAUSE;
      ST_STAT:  code = NS_STAT;
      default:  code = NS_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* src/cdt_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_ifs
// Valid/ready channels for timer events and timer results.
// ----------------------------------------------------------------------------
interface cdt_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [3:0] sub_second;

  modport source (output valid, output mode, output sub_second, input ready);
  modport sink   (input valid, input mode, input sub_second, output ready);
endinterface

interface cdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  new_state;
  logic        clear_display;
  logic [1:0]  message;
  logic        show_time;
  logic [15:0] time_value;
  logic        beep;

  modport source (output valid, output status, output new_state, output clear_display,
                  output message, output show_time, output time_value, output beep,
                  input ready);
  modport sink   (input valid, input status, input new_state, input clear_display,
                  input message, input show_time, input time_value, input beep,
                  output ready);
endinterface

/* src/cdt_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_cfg_regs
// APB-style configuration registers of the countdown timer.
// ----------------------------------------------------------------------------
module cdt_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdt_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output cdt_pkg::cfg_t               cfg
);
  import cdt_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[APB_AW-1:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step       <= RST_TIME_STEP;
      cfg.max_time        <= RST_MAX_TIME;
      cfg.count_divider   <= RST_COUNT_DIV;
      cfg.stat_hold_ticks <= RST_STAT_HOLD;
      cfg.beep_phase      <= RST_BEEP_PHASE;
    end else if (wr) begin
      unique case (idx)
        REG_TIME_STEP:  cfg.time_step       <= pwdata[7:0];
        REG_MAX_TIME:   cfg.max_time        <= pwdata[15:0];
        REG_COUNT_DIV:  cfg.count_divider   <= pwdata[7:0];
        REG_STAT_HOLD:  cfg.stat_hold_ticks <= pwdata[7:0];
        REG_BEEP_PHASE: cfg.beep_phase      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TIME_STEP:  prdata = {24'd0, cfg.time_step};
      REG_MAX_TIME:   prdata = {16'd0, cfg.max_time};
      REG_COUNT_DIV:  prdata = {24'd0, cfg.count_divider};
      REG_STAT_HOLD:  prdata = {24'd0, cfg.stat_hold_ticks};
      REG_BEEP_PHASE: prdata = {28'd0, cfg.beep_phase};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* src/cdt_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdt_fsm
// Timer state machine: state registers and the per-event next-state logic.
// ----------------------------------------------------------------------------
module cdt_fsm #(
  parameter int TIME_WIDTH = cdt_pkg::TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  cdt_pkg::cmd_t item,
  input  cdt_pkg::cfg_t cfg,
  output cdt_pkg::res_t res
);
  import cdt_pkg::*;

  localparam int CMP_W = (TIME_WIDTH >= 16) ? TIME_WIDTH + 1 : 17;

  state_t                phase, phase_next, target;
  logic [TIME_WIDTH-1:0] remaining, remaining_next;
  logic [TIME_WIDTH-1:0] elapsed, elapsed_next;
  logic [TIME_WIDTH-1:0] productive, productive_next;
  logic [7:0]            cd_ticks, cd_ticks_next;
  logic [7:0]            stat_ticks, stat_ticks_next;

  logic [TIME_WIDTH-1:0] step_w, rem_add, rem_sub, rem_dec, tval;
  logic [TIME_WIDTH+15:0] tval_ext;
  logic [CMP_W-1:0]      inc_sum;
  logic                  can_inc, can_dec, do_go;
  logic [7:0]            cd_inc, st_inc;
  logic [1:0]            status, msg;
  logic                  clr, show, beep;

  assign step_w  = TIME_WIDTH'(cfg.time_step);
  assign rem_add = remaining + step_w;
  assign rem_sub = remaining - step_w;
  assign rem_dec = (remaining != '0) ? remaining - 1'b1 : '0;
  // Limit check without wrap: widen both sides past either operand
  assign inc_sum = CMP_W'(remaining) + CMP_W'(cfg.time_step);
  assign can_inc = inc_sum < CMP_W'(cfg.max_time);
  assign can_dec = remaining >= step_w;
  assign cd_inc  = cd_ticks + 8'd1;
  assign st_inc  = stat_ticks + 8'd1;

  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    elapsed_next    = elapsed;
    productive_next = productive;
    cd_ticks_next   = cd_ticks;
    stat_ticks_next = stat_ticks;
    target          = phase;
    do_go           = 1'b0;
    status          = STATUS_IGNORED;
    msg             = MSG_NONE;
    clr             = 1'b0;
    show            = 1'b0;
    tval            = '0;
    beep            = 1'b0;

    unique case (phase)
      ST_IDLE: begin
        if (item.mode == MODE_INC) begin
          remaining_next = rem_add;
          do_go          = 1'b1;
          target         = ST_SET;
        end else if (item.mode == MODE_TICK) begin
          if (item.sub_second == cfg.beep_phase) begin
            beep   = 1'b1;
            status = STATUS_HANDLED;
          end
        end else if (item.mode == MODE_SS) begin
          do_go  = 1'b1;
          target = ST_STAT;
        end
      end
      ST_SET: begin
        if (item.mode == MODE_INC) begin
          status = STATUS_HANDLED;
          if (can_inc) begin
            remaining_next = rem_add;
            show           = 1'b1;
            tval           = rem_add;
          end
        end else if (item.mode == MODE_DEC) begin
          status = STATUS_HANDLED;
          if (can_dec) begin
            remaining_next = rem_sub;
            show           = 1'b1;
            tval           = rem_sub;
          end
        end else if (item.mode == MODE_SS) begin
          if (can_dec) begin
            do_go  = 1'b1;
            target = ST_CD;
          end
        end else if (item.mode == MODE_ABORT) begin
          do_go  = 1'b1;
          target = ST_IDLE;
        end
      end
      ST_CD: begin
        if (item.mode == MODE_TICK) begin
          cd_ticks_next = cd_inc;
          if (cd_inc >= cfg.count_divider) begin
            cd_ticks_next  = 8'd0;
            remaining_next = rem_dec;
            if (elapsed != '1) begin
              elapsed_next = elapsed + 1'b1;
            end
            show = 1'b1;
            tval = rem_dec;
            if (rem_dec == '0) begin
              do_go  = 1'b1;
              target = ST_IDLE;
            end else begin
              status = STATUS_HANDLED;
            end
          end
        end else if (item.mode == MODE_SS) begin
          do_go  = 1'b1;
          target = ST_PAUSE;
        end else if (item.mode == MODE_ABORT) begin
          do_go  = 1'b1;
          target = ST_IDLE;
        end
      end
      ST_PAUSE: begin
        if (item.mode == MODE_INC) begin
          if (can_inc) begin
            remaining_next = rem_add;
            do_go          = 1'b1;
            target         = ST_SET;
          end
        end else if (item.mode == MODE_DEC) begin
          if (can_dec) begin
            remaining_next = rem_sub;
            do_go          = 1'b1;
            target         = ST_SET;
          end
        end else if (item.mode == MODE_SS) begin
          do_go  = 1'b1;
          target = ST_CD;
        end else if (item.mode == MODE_ABORT) begin
          do_go  = 1'b1;
          target = ST_IDLE;
        end
      end
      ST_STAT: begin
        if (item.mode == MODE_TICK) begin
          stat_ticks_next = st_inc;
          if (st_inc >= cfg.stat_hold_ticks) begin
            stat_ticks_next = 8'd0;
            do_go           = 1'b1;
            target          = ST_IDLE;
          end
        end
      end
      default: ;
    endcase

    // Transition: exit action of the old state, then entry action of the new
    if (do_go) begin
      status     = STATUS_TRANSITION;
      phase_next = target;
      if (phase == ST_CD) begin
        productive_next = elapsed_next;
        elapsed_next    = '0;
      end else begin
        clr = 1'b1;
      end
      unique case (target)
        ST_IDLE: begin
          msg            = MSG_SET_TIME;
          show           = 1'b1;
          tval           = '0;
          remaining_next = '0;
          elapsed_next   = '0;
        end
        ST_SET: begin
          show = 1'b1;
          tval = remaining_next;
        end
        ST_PAUSE: msg = MSG_PAUSED;
        ST_STAT: begin
          msg  = MSG_PRODUCTIVE;
          show = 1'b1;
          tval = productive_next;
        end
        default: ;
      endcase
    end
  end

  assign tval_ext = {16'd0, tval};

  always_comb begin
    res.status        = status;
    res.new_state     = state_code(phase_next);
    res.clear_display = clr;
    res.message       = msg;
    res.show_time     = show;
    res.time_value    = tval_ext[15:0];
    res.beep          = beep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ST_IDLE;
      remaining  <= '0;
      elapsed    <= '0;
      productive <= '0;
      cd_ticks   <= 8'd0;
      stat_ticks <= 8'd0;
    end else if (fire) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      elapsed    <= elapsed_next;
      productive <= productive_next;
      cd_ticks   <= cd_ticks_next;
      stat_ticks <= stat_ticks_next;
    end
  end

endmodule

/* src/countdown_timer_pause_stat_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_pause_stat_core
// Five-state countdown timer with pause and statistics view, one event per
// request, one result per event.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - event requests (mode, sub_second), valid/ready.
//   rsp  - one result per event (status, new_state, display actions, beep).
//   APB  - five configuration registers at byte addresses 0x00..0x10;
//          write them only while no event is in flight. pready is tied high.
// Path: an accepted event passes the input register, then the state machine
//   feeds the result register.
// Throughput: one event per cycle unless rsp is held off; the state update
//   is compare, add or subtract and transition logic, all combinational.
// Stall: while rsp is held off, the result register holds and the input
//   register keeps one more request; cmd.ready drops only when both are full.
// Reset (rst, synchronous): state idle, remaining/elapsed/productive time
//   and both tick counters cleared, registers back to their defaults.
// ----------------------------------------------------------------------------
module countdown_timer_pause_stat_core #(
  parameter int TIME_WIDTH = cdt_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  cdt_cmd_if.sink                    cmd,
  cdt_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cdt_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cdt_pkg::*;

  cfg_t cfg;
  cmd_t s1_item;
  res_t res, out_res;
  logic s1_valid, out_valid, out_free, fire;

  assign pready = 1'b1;

  cdt_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Pipeline control: the result register frees when empty or being taken;
  // the input register advances into it whenever it frees.
  assign out_free  = !out_valid || rsp.ready;
  assign fire      = s1_valid && out_free;
  assign cmd.ready = !s1_valid || out_free;

  // Input register: capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_item.mode       <= cmd.mode;
      s1_item.sub_second <= cmd.sub_second;
    end
  end

  // State machine: advance state only when the event moves on
  cdt_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_res.status;
  assign rsp.new_state     = out_res.new_state;
  assign rsp.clear_display = out_res.clear_display;
  assign rsp.message       = out_res.message;
  assign rsp.show_time     = out_res.show_time;
  assign rsp.time_value    = out_res.time_value;
  assign rsp.beep          = out_res.beep;

`ifndef SYNTHESIS
  // A request stuck in the input register keeps its contents
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_item))
    else $error("input register lost or changed a stalled request");

  // An ignored event drives no display action and no beep
  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == STATUS_IGNORED |->
      !rsp.show_time && !rsp.beep && !rsp.clear_display && rsp.message == MSG_NONE)
    else $error("ignored event produced an action");

  // Entering idle always shows the set-time message with time zero
  a_idle_entry: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == STATUS_TRANSITION && rsp.new_state == NS_IDLE |->
      rsp.message == MSG_SET_TIME && rsp.show_time && rsp.time_value == 16'd0)
    else $error("idle entry action missing");

  // Beeps come only from a handled tick while idle
  a_beep_idle: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.beep |-> rsp.status == STATUS_HANDLED && rsp.new_state == NS_IDLE)
    else $error("beep outside idle");
`endif

endmodule

/* test/timer_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_result_checker
// Follows the event channel and the register port to predict each timer
// result, then compares every delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module timer_result_checker
  import cdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  cdt_cmd_if                cmd,
  cdt_rsp_if                rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending_results
);

  cfg_t        cfg;
  logic [2:0]  phase_q;
  logic [15:0] remaining;
  logic [15:0] elapsed;
  logic [15:0] productive;
  logic [7:0]  cd_ticks;
  logic [7:0]  st_ticks;
  res_t        pred;
  res_t        expected_results[$];
  int          errors;

  task automatic display_time(input logic [15:0] v);
    pred.show_time  = 1'b1;
    pred.time_value = v;
  endtask

  function automatic bit room_to_add();
    return (int'(remaining) + int'(cfg.time_step)) < int'(cfg.max_time);
  endfunction

  // Exit action of the old state, then entry action of the new one.
  task automatic change_state(input logic [2:0] next);
    if (phase_q == NS_COUNTDOWN) begin
      productive = elapsed;
      elapsed    = '0;
    end else begin
      pred.clear_display = 1'b1;
    end
    phase_q = next;
    case (next)
      NS_IDLE: begin
        pred.message = MSG_SET_TIME;
        display_time('0);
        remaining = '0;
        elapsed   = '0;
      end
      NS_TIME_SET: display_time(remaining);
      NS_PAUSE:    pred.message = MSG_PAUSED;
      NS_STAT: begin
        pred.message = MSG_PRODUCTIVE;
        display_time(productive);
      end
      default: ;
    endcase
    pred.status = STATUS_TRANSITION;
  endtask

  task automatic advance_timer(input cmd_t ev);
    pred = '0;
    pred.status = STATUS_IGNORED;
    case (phase_q)
      NS_IDLE: begin
        if (ev.mode == MODE_INC) begin
          remaining = remaining + 16'(cfg.time_step);
          change_state(NS_TIME_SET);
        end else if (ev.mode == MODE_TICK) begin
          if (ev.sub_second == cfg.beep_phase) begin
            pred.beep   = 1'b1;
            pred.status = STATUS_HANDLED;
          end
        end else if (ev.mode == MODE_SS) begin
          change_state(NS_STAT);
        end
      end
      NS_TIME_SET: begin
        if (ev.mode == MODE_INC) begin
          if (room_to_add()) begin
            remaining = remaining + 16'(cfg.time_step);
            display_time(remaining);
          end
          pred.status = STATUS_HANDLED;
        end else if (ev.mode == MODE_DEC) begin
          if (remaining >= 16'(cfg.time_step)) begin
            remaining = remaining - 16'(cfg.time_step);
            display_time(remaining);
          end
          pred.status = STATUS_HANDLED;
        end else if (ev.mode == MODE_SS) begin
          if (remaining >= 16'(cfg.time_step)) change_state(NS_COUNTDOWN);
        end else if (ev.mode == MODE_ABORT) begin
          change_state(NS_IDLE);
        end
      end
      NS_COUNTDOWN: begin
        if (ev.mode == MODE_TICK) begin
          cd_ticks = cd_ticks + 8'd1;
          if (cd_ticks >= cfg.count_divider) begin
            cd_ticks = '0;
            if (remaining != '0) remaining = remaining - 16'd1;
            if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
            display_time(remaining);
            if (remaining == '0) change_state(NS_IDLE);
            else pred.status = STATUS_HANDLED;
          end
        end else if (ev.mode == MODE_SS) begin
          change_state(NS_PAUSE);
        end else if (ev.mode == MODE_ABORT) begin
          change_state(NS_IDLE);
        end
      end
      NS_PAUSE: begin
        if (ev.mode == MODE_INC) begin
          if (room_to_add()) begin
            remaining = remaining + 16'(cfg.time_step);
            change_state(NS_TIME_SET);
          end
        end else if (ev.mode == MODE_DEC) begin
          if (remaining >= 16'(cfg.time_step)) begin
            remaining = remaining - 16'(cfg.time_step);
            change_state(NS_TIME_SET);
          end
        end else if (ev.mode == MODE_SS) begin
          change_state(NS_COUNTDOWN);
        end else if (ev.mode == MODE_ABORT) begin
          change_state(NS_IDLE);
        end
      end
      default: begin
        if (ev.mode == MODE_TICK) begin
          st_ticks = st_ticks + 8'd1;
          if (st_ticks >= cfg.stat_hold_ticks) begin
            st_ticks = '0;
            change_state(NS_IDLE);
          end
        end
      end
    endcase
    pred.new_state = phase_q;
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t seen;
    cmd_t ev;
    if (rst) begin
      cfg.time_step       = RST_TIME_STEP;
      cfg.max_time        = RST_MAX_TIME;
      cfg.count_divider   = RST_COUNT_DIV;
      cfg.stat_hold_ticks = RST_STAT_HOLD;
      cfg.beep_phase      = RST_BEEP_PHASE;
      phase_q    = NS_IDLE;
      remaining  = '0;
      elapsed    = '0;
      productive = '0;
      cd_ticks   = '0;
      st_ticks   = '0;
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen.status        = rsp.status;
        seen.new_state     = rsp.new_state;
        seen.clear_display = rsp.clear_display;
        seen.message       = rsp.message;
        seen.show_time     = rsp.show_time;
        seen.time_value    = rsp.time_value;
        seen.beep          = rsp.beep;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no event waiting: status=%0d state=%0d", $realtime,
                     seen.status, seen.new_state);
        end else begin
          want = expected_results.pop_front();
          if (seen.status !== want.status || seen.new_state !== want.new_state ||
              seen.clear_display !== want.clear_display || seen.message !== want.message ||
              seen.show_time !== want.show_time || seen.time_value !== want.time_value ||
              seen.beep !== want.beep) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: expected status=%0d state=%0d clr=%0d msg=%0d show=%0d time=%0d beep=%0d",
                       $realtime, want.status, want.new_state, want.clear_display,
                       want.message, want.show_time, want.time_value, want.beep);
              $display("%0t:   actual status=%0d state=%0d clr=%0d msg=%0d show=%0d time=%0d beep=%0d",
                       $realtime, seen.status, seen.new_state, seen.clear_display,
                       seen.message, seen.show_time, seen.time_value, seen.beep);
            end
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        ev.mode       = cmd.mode;
        ev.sub_second = cmd.sub_second;
        advance_timer(ev);
        expected_results.push_back(pred);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_TIME_STEP:  cfg.time_step       = pwdata[7:0];
          REG_MAX_TIME:   cfg.max_time        = pwdata[15:0];
          REG_COUNT_DIV:  cfg.count_divider   = pwdata[7:0];
          REG_STAT_HOLD:  cfg.stat_hold_ticks = pwdata[7:0];
          REG_BEEP_PHASE: cfg.beep_phase      = pwdata[3:0];
          default: ;
        endcase
      end
    end
    fail_count      <= errors;
    pending_results <= expected_results.size();
  end

endmodule

/* test/countdown_timer_pause_stat_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_pause_stat_core_test
// Drives timer events and register writes into the countdown timer core with
// random idling on both channels; the checker beside the core predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module countdown_timer_pause_stat_core_test;
  import cdt_pkg::*;

  // Mode codes the core has no action for
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending_results;
  // Set for the last stretch of the run: no idling on either side
  bit                steady;

  cdt_cmd_if cmd_ch ();
  cdt_rsp_if rsp_ch ();

  countdown_timer_pause_stat_core dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  timer_result_checker tracker (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd_ch),
    .rsp             (rsp_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run (about 800 requests, each
  // with its worst gap and stall, plus the drains between phases).
  initial begin
    #5_000_000;
    $display("countdown_timer_pause_stat_core_test NOT OK");
    $finish;
  end

  // Result side: hold ready low in random bursts, with open stretches of random
  // length in between; keep it high once the run turns steady.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Setup cycle, then access cycle; the register takes the data at the edge
  // where penable and pready are both high.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back, then let
  // the two pipeline stages run empty.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers; only ever done with no event in flight.
  task automatic set_config(input logic [7:0] step, input logic [15:0] limit,
                            input logic [7:0] divider, input logic [7:0] hold,
                            input logic [3:0] beep_at);
    settle();
    write_reg(REG_TIME_STEP, 32'(step));
    write_reg(REG_MAX_TIME, 32'(limit));
    write_reg(REG_COUNT_DIV, 32'(divider));
    write_reg(REG_STAT_HOLD, 32'(hold));
    write_reg(REG_BEEP_PHASE, 32'(beep_at));
  endtask

  // Offer one request, maybe after a random gap, and hold it until accepted.
  // valid stays high afterwards so back-to-back requests need no extra step.
  task automatic send_event(input logic [2:0] m, input logic [3:0] sub);
    if (!steady && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.mode       <= m;
    cmd_ch.sub_second <= sub;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  initial begin
    int         p;
    int         n;
    int         pick;
    logic [2:0] m;
    logic [7:0] step;
    logic [15:0] limit;

    rst               <= 1'b1;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.mode       <= MODE_INC;
    cmd_ch.sub_second <= 4'd0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    steady             = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk every state with tiny limits: step 1, max 3, one tick per second,
    // one tick of statistics, beep on the top phase.
    set_config(8'd1, 16'd3, 8'd1, 8'd1, 4'd15);
    send_event(MODE_TICK, 4'd15);      // idle beep
    send_event(MODE_TICK, 4'd0);       // idle tick off phase: ignored
    send_event(MODE_DEC, 4'd15);       // no action in idle
    send_event(MODE_SPARE_LO, 4'd0);   // unknown mode
    send_event(MODE_INC, 4'd0);        // idle to time set, no limit check
    send_event(MODE_INC, 4'd0);        // 1 + 1 < 3: step up
    send_event(MODE_INC, 4'd0);        // 2 + 1 hits the limit: held
    send_event(MODE_DEC, 4'd0);
    send_event(MODE_SPARE_HI, 4'd9);
    send_event(MODE_SS, 4'd0);         // start countdown
    send_event(MODE_SS, 4'd0);         // pause
    send_event(MODE_DEC, 4'd0);        // pause back to time set at zero
    send_event(MODE_SS, 4'd0);         // zero below step: no start
    send_event(MODE_INC, 4'd0);
    send_event(MODE_SS, 4'd0);
    send_event(MODE_TICK, 4'd0);       // last second: back to idle
    send_event(MODE_SS, 4'd0);         // statistics shows productive time
    send_event(MODE_TICK, 4'd3);       // hold expires
    send_event(MODE_ABORT, 4'd0);      // no action in idle

    // Zero step, zero limit, zero divider and hold: the limit check blocks every
    // step up in time set and the statistics hold expires on its first tick.
    set_config(8'd0, 16'd0, 8'd0, 8'd0, 4'd0);
    send_event(MODE_INC, 4'd0);
    send_event(MODE_INC, 4'd0);
    send_event(MODE_DEC, 4'd0);
    send_event(MODE_SS, 4'd0);
    send_event(MODE_SS, 4'd0);
    send_event(MODE_ABORT, 4'd0);      // abort out of pause
    send_event(MODE_SS, 4'd0);         // idle to statistics
    send_event(MODE_TICK, 4'd0);

    // Random phases, each under its own register setting.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_config(RST_TIME_STEP, RST_MAX_TIME, RST_COUNT_DIV, RST_STAT_HOLD,
                      RST_BEEP_PHASE);
        1: set_config(8'd255, 16'd65535, 8'd255, 8'd255, 4'd15);
        2: set_config(8'd1, 16'd1, 8'd1, 8'd1, 4'd0);
        default: begin
          step  = 8'($urandom_range(1, 255));
          // Either any nonzero limit, or 2 to 20 times the step size
          limit = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 65535)) :
                                                16'(step * $urandom_range(2, 20));
          set_config(step, limit, 8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)),
                     4'($urandom_range(0, 15)));
        end
      endcase
      for (n = 0; n < 125; n++) begin
        if (p == 5 && n == 25) steady = 1'b1;
        // Lean on ticks and start/stop so the countdown and the statistics
        // view actually run to completion.
        pick = $urandom_range(0, 99);
        if (pick < 18)      m = MODE_INC;
        else if (pick < 28) m = MODE_DEC;
        else if (pick < 70) m = MODE_TICK;
        else if (pick < 86) m = MODE_SS;
        else if (pick < 93) m = MODE_ABORT;
        else                m = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        send_event(m, 4'($urandom_range(0, 15)));
        // Hold the sender once mid-phase until the core has drained
        if (p == 3 && n == 60) settle();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("countdown_timer_pause_stat_core_test OK");
    end else begin
      $display("countdown_timer_pause_stat_core_test NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
src/cdt_pkg.sv
src/cdt_ifs.sv
src/cdt_cfg_regs.sv
src/cdt_fsm.sv
src/countdown_timer_pause_stat_core.sv
test/timer_result_checker.sv
test/countdown_timer_pause_stat_core_test.sv
